/* rtl/core/sorted_min_priority_queue_macros.svh */
// assertion macros for the sorted min priority queue
// used by the rtl files that carry concurrent assertions
`ifndef SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH

// same cycle implication, disabled in reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next cycle implication, disabled in reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/spq_pkg.sv */
// shared types and constants for the sorted min priority queue
// no dependencies
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 5;
    localparam int STATUS_W  = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [VALUE_W-1:0] value;
    } t_cell_ctl;

endpackage

/* rtl/core/spq_cell.sv */
// one storage cell of the sorted chain: holds one entry and compares it
// with the broadcast value; depends on spq_pkg
module spq_cell
    import spq_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic               i_valid,
    input  logic               i_left_ins,
    input  logic [VALUE_W-1:0] i_left_entry,
    input  logic [VALUE_W-1:0] i_right_entry,
    output logic               o_ins,
    output logic [VALUE_W-1:0] o_entry,
    output logic [VALUE_W-1:0] o_next_entry
);

    logic [VALUE_W-1:0] r_entry;
    logic [VALUE_W-1:0] n_entry;
    logic               ins;

    // new value belongs at or before this cell
    assign ins = i_valid ? ($signed(i_ctl.value) < $signed(r_entry)) : 1'b1;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.pop) begin
            n_entry = i_right_entry;
        end else if (i_ctl.push && ins) begin
            n_entry = i_left_ins ? i_left_entry : i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_ins        = ins;
    assign o_entry      = r_entry;
    assign o_next_entry = n_entry;

endmodule

/* rtl/core/sorted_min_priority_queue.sv */
// Sorted min priority queue: a chain of DEPTH compare-and-shift cells keeps the
// entries in ascending order, smallest at the front. An item (push or pop) is
// taken in every cycle while the output register is free or being drained; all
// cells update in that same cycle from the broadcast value and their
// neighbors, and the result is registered and offered in the next cycle.
// Throughput is one item per cycle while the output is not stalled, set by
// the cell update and one output register. A push on a full queue is
// rejected and a pop on an empty one ignored, both flagged in status.
// top level; depends on spq_pkg, spq_cell and the assertion macro header
`include "sorted_min_priority_queue_macros.svh"

module sorted_min_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [0:0]  s_axis_tuser,   // opcode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // popped_value[31:0], front_value[63:32],
                                        // is_empty[64], entry_count[69:65],
                                        // status[71:70]
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic [71:0]        r_out_data;

    logic               accept;
    logic               is_push;
    logic               full;
    logic               empty;
    t_cell_ctl          ctl;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0] popped;
    logic [VALUE_W-1:0] front;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    logic [DEPTH-1:0]   cell_ins;
    logic [VALUE_W-1:0] cell_entry [DEPTH];
    logic [VALUE_W-1:0] cell_next  [DEPTH];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_push       = (s_axis_tuser[0] == OP_PUSH);
    assign full          = (r_count == CNT_W'(DEPTH));
    assign empty         = (r_count == '0);

    assign ctl.push  = accept && is_push && !full;
    assign ctl.pop   = accept && !is_push && !empty;
    assign ctl.value = s_axis_tdata;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic               left_ins;
            logic [VALUE_W-1:0] left_entry;
            logic [VALUE_W-1:0] right_entry;
            if (gi == 0) begin : g_first
                assign left_ins   = 1'b0;
                assign left_entry = '0;
            end else begin : g_mid
                assign left_ins   = cell_ins[gi-1];
                assign left_entry = cell_entry[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_entry = '0;
            end else begin : g_inner
                assign right_entry = cell_entry[gi+1];
            end
            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (ctl),
                .i_valid       (CNT_W'(gi) < r_count),
                .i_left_ins    (left_ins),
                .i_left_entry  (left_entry),
                .i_right_entry (right_entry),
                .o_ins         (cell_ins[gi]),
                .o_entry       (cell_entry[gi]),
                .o_next_entry  (cell_next[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        status  = ST_OK;
        popped  = '0;
        if (ctl.push) begin
            n_count = r_count + 1'b1;
        end else if (ctl.pop) begin
            n_count = r_count - 1'b1;
            popped  = cell_entry[0];
        end
        if (is_push && full) begin
            status = ST_PUSH_FULL;
        end else if (!is_push && empty) begin
            status = ST_POP_EMPTY;
        end
        front     = (n_count != '0) ? cell_next[0] : '0;
        count_ext = {{COUNT_W{1'b0}}, n_count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {status, count_ext[COUNT_W-1:0], (n_count == '0), front, popped};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH),
        "entry count above depth")
    `SPQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, ctl.push,
        r_count == $past(r_count) + 1'b1, "accepted push did not grow the count")
    `SPQ_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_out_valid && !m_axis_tready,
        $stable(r_count), "queue changed while the result stalled")
    `SPQ_ASSERT_NOW(a_front_sorted, i_clk, i_rst_n, r_count >= CNT_W'(2),
        $signed(cell_entry[0]) <= $signed(cell_entry[1]), "front entry out of order")

endmodule
